// ===== rtl/r2q_pkg.sv =====
// ----------------------------------------------------------------------------
// r2q_pkg
// Shared types and constants for the rotation matrix to quaternion converter.
// ----------------------------------------------------------------------------
package r2q_pkg;

	// fixed point format of matrix elements and quaternion components
	localparam int FRAC = 14;
	localparam int ONE  = 1 << FRAC;

	// width of the clamped radicand and of one difference magnitude
	localparam int RAD_W = 17;
	localparam int DIF_W = 17;

	// branch of the conversion: trace branch or largest diagonal element
	typedef enum logic [1:0] {
		BR_W,
		BR_X,
		BR_Y,
		BR_Z
	} branch_t;

	// classified word handed from the front part to the back part
	typedef struct packed {
		logic [RAD_W-1:0]           rad;
		logic [2:0][DIF_W-1:0]      dmag;
		logic [2:0]                 dneg;
		branch_t                    diag;
	} cls_t;

endpackage

// ===== rtl/r2q_front.sv =====
// ----------------------------------------------------------------------------
// r2q_front
// Takes a matrix word, forms the trace, picks the branch, the clamped
// radicand and the three off-diagonal sums or differences.
// ----------------------------------------------------------------------------
module r2q_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic signed [15:0]    forward_x,
	input  logic signed [15:0]    forward_y,
	input  logic signed [15:0]    forward_z,
	input  logic signed [15:0]    right_x,
	input  logic signed [15:0]    right_y,
	input  logic signed [15:0]    right_z,
	input  logic signed [15:0]    up_x,
	input  logic signed [15:0]    up_y,
	input  logic signed [15:0]    up_z,
	output logic                  out_valid,
	output r2q_pkg::cls_t         out_data,
	input  logic                  out_ready
);
	import r2q_pkg::*;

	logic signed [17:0] tr;
	logic signed [18:0] rad;
	logic signed [17:0] dif [3];
	branch_t            diag;
	cls_t               cls;
	logic               vld_s1;
	cls_t               cls_s1;

	// trace and branch choice
	always_comb begin
		tr = 18'(forward_x) + 18'(right_y) + 18'(up_z);
		if (tr > 18'sd0) begin
			diag   = BR_W;
			rad    = 19'(ONE) + 19'(tr);
			dif[0] = 18'(right_z) - 18'(up_y);
			dif[1] = 18'(up_x) - 18'(forward_z);
			dif[2] = 18'(forward_y) - 18'(right_x);
		end else if (forward_x > right_y && forward_x > up_z) begin
			diag   = BR_X;
			rad    = 19'(ONE) + 19'(forward_x) - 19'(right_y) - 19'(up_z);
			dif[0] = 18'(right_z) - 18'(up_y);
			dif[1] = 18'(right_x) + 18'(forward_y);
			dif[2] = 18'(up_x) + 18'(forward_z);
		end else if (right_y > up_z) begin
			diag   = BR_Y;
			rad    = 19'(ONE) + 19'(right_y) - 19'(forward_x) - 19'(up_z);
			dif[0] = 18'(up_x) - 18'(forward_z);
			dif[1] = 18'(right_x) + 18'(forward_y);
			dif[2] = 18'(up_y) + 18'(right_z);
		end else begin
			diag   = BR_Z;
			rad    = 19'(ONE) + 19'(up_z) - 19'(forward_x) - 19'(right_y);
			dif[0] = 18'(forward_y) - 18'(right_x);
			dif[1] = 18'(up_x) + 18'(forward_z);
			dif[2] = 18'(up_y) + 18'(right_z);
		end
	end

	// clamp and split into sign and magnitude
	always_comb begin
		cls.diag = diag;
		cls.rad  = rad[18] ? '0 : rad[RAD_W-1:0];
		for (int k = 0; k < 3; k++) begin
			cls.dneg[k] = dif[k][17];
			cls.dmag[k] = dif[k][17] ? DIF_W'(-dif[k]) : DIF_W'(dif[k]);
		end
	end

	// one register stage toward the queue
	assign in_stall  = vld_s1 && !out_ready;
	assign out_valid = vld_s1;
	assign out_data  = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cls_s1 <= cls;
		end
	end

endmodule

// ===== rtl/r2q_fifo.sv =====
// ----------------------------------------------------------------------------
// r2q_fifo
// Short queue of classified words between the front and the back part.
// ----------------------------------------------------------------------------
module r2q_fifo #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  r2q_pkg::cls_t   push_data,
	output logic            push_ready,
	output logic            pop_valid,
	output r2q_pkg::cls_t   pop_data,
	input  logic            pop_ready
);
	import r2q_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cls_t           mem_q [DEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = cnt_q != CW'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/r2q_sqrt.sv =====
// ----------------------------------------------------------------------------
// r2q_sqrt
// Pipelined integer square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module r2q_sqrt #(
	parameter int K  = 16,
	parameter int PW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [2*K-1:0]  in_rad,
	input  logic [PW-1:0]   in_pay,
	output logic            out_valid,
	output logic [K-1:0]    out_root,
	output logic [PW-1:0]   out_pay
);
	localparam int RW = K + 3;

	logic [K-1:0]   vld_q;
	logic [RW-1:0]  rem_q  [K];
	logic [K-1:0]   root_q [K];
	logic [2*K-1:0] rad_q  [K];
	logic [PW-1:0]  pay_q  [K];
	logic [RW-1:0]  rem_n  [K];
	logic [K-1:0]   root_n [K];
	logic [2*K-1:0] rad_n  [K];
	logic [PW-1:0]  pay_n  [K];

	// one restoring step per stage, two radicand bits each
	always_comb begin
		logic [RW-1:0]  remp;
		logic [RW-1:0]  remsh;
		logic [RW-1:0]  trial;
		logic [K-1:0]   rootp;
		logic [2*K-1:0] radp;
		for (int i = 0; i < K; i++) begin
			if (i == 0) begin
				remp     = '0;
				rootp    = '0;
				radp     = in_rad;
				pay_n[i] = in_pay;
			end else begin
				remp     = rem_q[i-1];
				rootp    = root_q[i-1];
				radp     = rad_q[i-1];
				pay_n[i] = pay_q[i-1];
			end
			rad_n[i] = radp;
			remsh    = {remp[RW-3:0], radp[2*K-1-2*i -: 2]};
			trial    = RW'({rootp, 2'b01});
			if (remsh >= trial) begin
				rem_n[i]  = remsh - trial;
				root_n[i] = {rootp[K-2:0], 1'b1};
			end else begin
				rem_n[i]  = remsh;
				root_n[i] = {rootp[K-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[K-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < K; i++) begin
				rem_q[i]  <= rem_n[i];
				root_q[i] <= root_n[i];
				rad_q[i]  <= rad_n[i];
				pay_q[i]  <= pay_n[i];
			end
		end
	end

	assign out_valid = vld_q[K-1];
	assign out_root  = root_q[K-1];
	assign out_pay   = pay_q[K-1];

endmodule

// ===== rtl/r2q_div.sv =====
// ----------------------------------------------------------------------------
// r2q_div
// Pipelined unsigned divider, one quotient bit per stage, several lanes
// sharing one divisor, with sideband.
// ----------------------------------------------------------------------------
module r2q_div #(
	parameter int N  = 31,
	parameter int D  = 17,
	parameter int Q  = 23,
	parameter int L  = 3,
	parameter int PW = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [L-1:0][N-1:0]  in_num,
	input  logic [D-1:0]         in_den,
	input  logic [PW-1:0]        in_pay,
	output logic                 out_valid,
	output logic [L-1:0][Q-1:0]  out_quot,
	output logic [PW-1:0]        out_pay
);
	localparam int WW = N + D + Q;

	logic [Q-1:0]            vld_q;
	logic [L-1:0][N-1:0]     rem_q  [Q];
	logic [L-1:0][Q-1:0]     quot_q [Q];
	logic [D-1:0]            den_q  [Q];
	logic [PW-1:0]           pay_q  [Q];
	logic [L-1:0][N-1:0]     rem_n  [Q];
	logic [L-1:0][Q-1:0]     quot_n [Q];
	logic [D-1:0]            den_n  [Q];
	logic [PW-1:0]           pay_n  [Q];

	// stage i decides quotient bit Q-1-i
	always_comb begin
		logic [L-1:0][N-1:0] remp;
		logic [L-1:0][Q-1:0] quotp;
		logic [WW-1:0]       shd;
		logic [WW-1:0]       ext;
		for (int i = 0; i < Q; i++) begin
			if (i == 0) begin
				remp     = in_num;
				quotp    = '0;
				den_n[i] = in_den;
				pay_n[i] = in_pay;
			end else begin
				remp     = rem_q[i-1];
				quotp    = quot_q[i-1];
				den_n[i] = den_q[i-1];
				pay_n[i] = pay_q[i-1];
			end
			shd = WW'(den_n[i]) << (Q - 1 - i);
			for (int l = 0; l < L; l++) begin
				ext = WW'(remp[l]);
				if (ext >= shd) begin
					rem_n[i][l]  = N'(ext - shd);
					quot_n[i][l] = {quotp[l][Q-2:0], 1'b1};
				end else begin
					rem_n[i][l]  = remp[l];
					quot_n[i][l] = {quotp[l][Q-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[Q-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < Q; i++) begin
				rem_q[i]  <= rem_n[i];
				quot_q[i] <= quot_n[i];
				den_q[i]  <= den_n[i];
				pay_q[i]  <= pay_n[i];
			end
		end
	end

	assign out_valid = vld_q[Q-1];
	assign out_quot  = quot_q[Q-1];
	assign out_pay   = pay_q[Q-1];

endmodule

// ===== rtl/r2q_back.sv =====
// ----------------------------------------------------------------------------
// r2q_back
// Scale root, component divisions, norm and final normalizing divisions.
// The whole chain advances together unless the output word is held.
// ----------------------------------------------------------------------------
module r2q_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	input  r2q_pkg::cls_t       pop_data,
	output logic                pop_ready,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [15:0]  quat_w,
	output logic signed [15:0]  quat_x,
	output logic signed [15:0]  quat_y,
	output logic signed [15:0]  quat_z,
	output logic                degenerate
);
	import r2q_pkg::*;

	localparam int R1W = 16;             // root of the scaled radicand
	localparam int N1W = 31;             // first dividend
	localparam int Q1W = 23;             // component magnitude
	localparam int SQW = 2 * Q1W;        // one square
	localparam int R2W = 24;             // norm
	localparam int N2W = Q1W + FRAC + 1; // second dividend
	localparam int Q2W = 15;             // unit component magnitude

	typedef struct packed {
		branch_t         diag;
		logic [2:0]      dneg;
		logic [R1W-2:0]  cdiag;
		logic            zero;
	} sb1_t;

	typedef struct packed {
		logic [3:0][Q1W-1:0] c;
		logic [3:0]          neg;
		logic                zero;
	} sb2_t;

	typedef struct packed {
		logic [3:0] neg;
		logic       deg;
	} sb3_t;

	logic                     adv;
	sb1_t                     sb1_in;
	logic                     sq1_vld;
	logic [R1W-1:0]           root1;
	logic [$bits(cls_t)-1:0]  sq1_pay;
	cls_t                     cls1;
	logic [2:0][N1W-1:0]      num1;
	logic                     dv1_vld;
	logic [2:0][Q1W-1:0]      quo1;
	logic [$bits(sb1_t)-1:0]  dv1_pay;
	sb1_t                     sb1;
	logic [3:0][Q1W-1:0]      cmag;
	logic [3:0]               cneg;
	logic                     vld_s1;
	logic [3:0][Q1W-1:0]      c_s1;
	logic [3:0]               neg_s1;
	logic                     zero_s1;
	logic [3:0][SQW-1:0]      sq_s1;
	logic                     vld_s2;
	logic [3:0][Q1W-1:0]      c_s2;
	logic [3:0]               neg_s2;
	logic                     zero_s2;
	logic [2*R2W-1:0]         sum_s2;
	sb2_t                     sb2_in;
	logic                     sq2_vld;
	logic [R2W-1:0]           root2;
	logic [$bits(sb2_t)-1:0]  sq2_pay;
	sb2_t                     sb2;
	logic [3:0][N2W-1:0]      num2;
	sb3_t                     sb3_in;
	logic                     dv2_vld;
	logic [3:0][Q2W-1:0]      quo2;
	logic [$bits(sb3_t)-1:0]  dv2_pay;
	sb3_t                     sb3;
	logic [3:0][15:0]         res;
	logic                     out_valid_q;
	logic [3:0][15:0]         quat_q;
	logic                     deg_q;

	// chain moves unless a finished word is held at the output
	assign adv       = !(out_valid_q && out_stall);
	assign pop_ready = adv;

	// scale root: floor(sqrt(r << FRAC))
	r2q_sqrt #(.K(R1W), .PW($bits(cls_t))) u_sqrt_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (pop_valid),
		.in_rad    ((2*R1W)'(pop_data.rad) << FRAC),
		.in_pay    (pop_data),
		.out_valid (sq1_vld),
		.out_root  (root1),
		.out_pay   (sq1_pay)
	);

	// off-diagonal components: round(d << FRAC / s), s = 2 * root
	always_comb begin
		cls1         = cls_t'(sq1_pay);
		sb1_in.diag  = cls1.diag;
		sb1_in.dneg  = cls1.dneg;
		sb1_in.cdiag = root1[R1W-1:1];
		sb1_in.zero  = root1 == '0;
		for (int k = 0; k < 3; k++) begin
			num1[k] = (N1W'(cls1.dmag[k]) << FRAC) + N1W'(root1);
		end
	end

	r2q_div #(.N(N1W), .D(R1W + 1), .Q(Q1W), .L(3), .PW($bits(sb1_t))) u_div_comp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (sq1_vld),
		.in_num    (num1),
		.in_den    ({root1, 1'b0}),
		.in_pay    (sb1_in),
		.out_valid (dv1_vld),
		.out_quot  (quo1),
		.out_pay   (dv1_pay)
	);

	// put the diagonal component back in its place
	always_comb begin
		sb1 = sb1_t'(dv1_pay);
		unique case (sb1.diag)
			BR_W: begin
				cmag = {quo1[2], quo1[1], quo1[0], Q1W'(sb1.cdiag)};
				cneg = {sb1.dneg[2], sb1.dneg[1], sb1.dneg[0], 1'b0};
			end
			BR_X: begin
				cmag = {quo1[2], quo1[1], Q1W'(sb1.cdiag), quo1[0]};
				cneg = {sb1.dneg[2], sb1.dneg[1], 1'b0, sb1.dneg[0]};
			end
			BR_Y: begin
				cmag = {quo1[2], Q1W'(sb1.cdiag), quo1[1], quo1[0]};
				cneg = {sb1.dneg[2], 1'b0, sb1.dneg[1], sb1.dneg[0]};
			end
			BR_Z: begin
				cmag = {Q1W'(sb1.cdiag), quo1[2], quo1[1], quo1[0]};
				cneg = {1'b0, sb1.dneg[2], sb1.dneg[1], sb1.dneg[0]};
			end
			default: begin
				cmag = '0;
				cneg = '0;
			end
		endcase
	end

	// squares, then their sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= dv1_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1    <= cmag;
			neg_s1  <= cneg;
			zero_s1 <= sb1.zero;
			for (int k = 0; k < 4; k++) begin
				sq_s1[k] <= cmag[k] * cmag[k];
			end
			c_s2    <= c_s1;
			neg_s2  <= neg_s1;
			zero_s2 <= zero_s1;
			sum_s2  <= (2*R2W)'(sq_s1[0]) + (2*R2W)'(sq_s1[1])
				+ (2*R2W)'(sq_s1[2]) + (2*R2W)'(sq_s1[3]);
		end
	end

	// norm
	always_comb begin
		sb2_in.c    = c_s2;
		sb2_in.neg  = neg_s2;
		sb2_in.zero = zero_s2;
	end

	r2q_sqrt #(.K(R2W), .PW($bits(sb2_t))) u_sqrt_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s2),
		.in_rad    (sum_s2),
		.in_pay    (sb2_in),
		.out_valid (sq2_vld),
		.out_root  (root2),
		.out_pay   (sq2_pay)
	);

	// unit components: round(c << FRAC / n)
	always_comb begin
		sb2        = sb2_t'(sq2_pay);
		sb3_in.neg = sb2.neg;
		sb3_in.deg = sb2.zero || root2 == '0;
		for (int k = 0; k < 4; k++) begin
			num2[k] = (N2W'(sb2.c[k]) << FRAC) + N2W'(root2[R2W-1:1]);
		end
	end

	r2q_div #(.N(N2W), .D(R2W), .Q(Q2W), .L(4), .PW($bits(sb3_t))) u_div_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (sq2_vld),
		.in_num    (num2),
		.in_den    (root2),
		.in_pay    (sb3_in),
		.out_valid (dv2_vld),
		.out_quot  (quo2),
		.out_pay   (dv2_pay)
	);

	// signs back on, identity when degenerate
	always_comb begin
		sb3 = sb3_t'(dv2_pay);
		for (int k = 0; k < 4; k++) begin
			if (sb3.deg) begin
				res[k] = (k == 0) ? 16'(ONE) : '0;
			end else begin
				res[k] = sb3.neg[k] ? -(16'(quo2[k])) : 16'(quo2[k]);
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dv2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			quat_q <= res;
			deg_q  <= sb3.deg;
		end
	end

	assign out_valid  = out_valid_q;
	assign quat_w     = quat_q[0];
	assign quat_x     = quat_q[1];
	assign quat_y     = quat_q[2];
	assign quat_z     = quat_q[3];
	assign degenerate = deg_q;

endmodule

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Rotation matrix (Q2.14 columns forward, right, up) to unit quaternion.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle unless the output is stalled, set by the fully
// pipelined root and divide units (one result bit per stage) of the back part.
// From input accept to output valid, a word passes the front register, the
// queue, root units (16 and 24 stages), dividers (23 and 15) and back registers.
// Reset clears the valid bits of every stage and the queue pointers.
module rotation_matrix_to_quaternion #(
	parameter int QDEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [15:0]  forward_x,
	input  logic signed [15:0]  forward_y,
	input  logic signed [15:0]  forward_z,
	input  logic signed [15:0]  right_x,
	input  logic signed [15:0]  right_y,
	input  logic signed [15:0]  right_z,
	input  logic signed [15:0]  up_x,
	input  logic signed [15:0]  up_y,
	input  logic signed [15:0]  up_z,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [15:0]  quat_w,
	output logic signed [15:0]  quat_x,
	output logic signed [15:0]  quat_y,
	output logic signed [15:0]  quat_z,
	output logic                degenerate
);
	import r2q_pkg::*;

	logic  push_valid;
	cls_t  push_data;
	logic  push_ready;
	logic  pop_valid;
	cls_t  pop_data;
	logic  pop_ready;

	// classify each word
	r2q_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.forward_x (forward_x),
		.forward_y (forward_y),
		.forward_z (forward_z),
		.right_x   (right_x),
		.right_y   (right_y),
		.right_z   (right_z),
		.up_x      (up_x),
		.up_y      (up_y),
		.up_z      (up_z),
		.out_valid (push_valid),
		.out_data  (push_data),
		.out_ready (push_ready)
	);

	// decoupling queue
	r2q_fifo #(.DEPTH(QDEPTH)) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	// arithmetic pipeline
	r2q_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.quat_w     (quat_w),
		.quat_x     (quat_x),
		.quat_y     (quat_y),
		.quat_z     (quat_z),
		.degenerate (degenerate)
	);

endmodule
